// ===== rtl/fifo_and_priority_dual_server_top_macros.svh =====
// Assertion macros for the dual-policy request queue.
`ifndef FIFO_AND_PRIORITY_DUAL_SERVER_TOP_MACROS_SVH
`define FIFO_AND_PRIORITY_DUAL_SERVER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define FPDS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define FPDS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/fpds_pkg.sv =====
// Package with shared constants, codes and control structs of the request queue.
`timescale 1ns / 1ps
package fpds_pkg;
	localparam int CAPACITY = 1024;
	localparam int ID_W = 11;
	localparam int ADDR_W = 10;
	localparam int VIN_W = 20;

	localparam logic [1:0] KIND_ARRIVE = 2'd0;
	localparam logic [1:0] KIND_OLDEST = 2'd1;
	localparam logic [1:0] KIND_HIGHEST = 2'd2;

	localparam logic [1:0] ST_SERVED = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic arr_commit;
		logic up_rd;
		logic up_move;
		logic up_place;
		logic fifo_pop;
		logic hpop_rd;
		logic h_take;
		logic dn_move;
		logic dn_place;
		logic mark_set;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic fifo_empty;
		logic heap_empty;
		logic up_root;
		logic up_go;
		logic dn_end;
		logic dn_go;
		logic marked;
	} stat_t;
endpackage

// ===== rtl/fpds_dp.sv =====
// Datapath of the request queue: counters, heap memory and served marks.
`timescale 1ns / 1ps
module fpds_dp #(
	parameter int VALUE_WIDTH = 20
) (
	input  logic clk,
	input  logic arst_n,
	input  logic [fpds_pkg::VIN_W-1:0] value,
	input  fpds_pkg::cmd_t cmd,
	output fpds_pkg::stat_t stat,
	output logic [fpds_pkg::ID_W-1:0] id
);
	localparam int ENT_W = VALUE_WIDTH + fpds_pkg::ID_W;
	localparam int ID_W = fpds_pkg::ID_W;
	localparam int AW = fpds_pkg::ADDR_W;

	logic [ID_W-1:0] next_id_q;
	logic [ID_W-1:0] fifo_cnt_q;
	logic [ID_W-1:0] size_q;
	logic [AW-1:0] pos_q;
	logic [ID_W-1:0] id_q;
	logic [ENT_W-1:0] item_q;
	logic [ENT_W-1:0] last_q;
	logic [ENT_W-1:0] rd0_q;
	logic [ENT_W-1:0] rd1_q;
	logic mark_q;

	logic [ENT_W-1:0] heap_mem [fpds_pkg::CAPACITY];
	logic marks_mem [fpds_pkg::CAPACITY];

	logic [31:0] vpad;
	logic [VALUE_WIDTH-1:0] vmask;
	logic [ID_W-1:0] c_idx;
	logic [ID_W:0] c1_idx;
	logic [AW-1:0] up_idx;
	logic pick1;
	logic [ENT_W-1:0] child;
	logic heap_we;
	logic [ENT_W-1:0] heap_wd;
	logic [AW-1:0] ra0;
	logic [AW-1:0] ra1;
	logic mark_we;
	logic mark_wd;
	logic [AW-1:0] mark_wa;
	logic [AW-1:0] id_m1;

	function automatic logic [ENT_W-1:0] rank_key(input logic [ENT_W-1:0] e);
		return {e[ENT_W-1:ID_W], ~e[ID_W-1:0]};
	endfunction

	assign vpad = 32'(value);
	assign vmask = vpad[VALUE_WIDTH-1:0];
	assign c_idx = {pos_q, 1'b1};
	assign c1_idx = {1'b0, c_idx} + (ID_W+1)'(1);
	assign up_idx = AW'((pos_q - AW'(1)) >> 1);
	assign pick1 = (c1_idx < {1'b0, size_q}) && (rank_key(rd1_q) > rank_key(rd0_q));
	assign child = pick1 ? rd1_q : rd0_q;
	assign id_m1 = AW'(id_q - ID_W'(1));

	always_comb begin
		stat.full = next_id_q > ID_W'(fpds_pkg::CAPACITY);
		stat.fifo_empty = fifo_cnt_q == '0;
		stat.heap_empty = size_q == '0;
		stat.up_root = pos_q == '0;
		stat.up_go = rank_key(item_q) > rank_key(rd0_q);
		stat.dn_end = c_idx >= size_q;
		stat.dn_go = rank_key(child) > rank_key(last_q);
		stat.marked = mark_q;
	end

	always_comb begin
		heap_we = cmd.up_move | cmd.up_place | cmd.dn_move | cmd.dn_place;
		heap_wd = last_q;
		if (cmd.up_move) begin
			heap_wd = rd0_q;
		end else if (cmd.up_place) begin
			heap_wd = item_q;
		end else if (cmd.dn_move) begin
			heap_wd = child;
		end
		ra0 = c_idx[AW-1:0];
		ra1 = c1_idx[AW-1:0];
		if (cmd.up_rd) begin
			ra0 = up_idx;
		end else if (cmd.hpop_rd) begin
			ra0 = '0;
			ra1 = AW'(size_q - ID_W'(1));
		end
		mark_we = cmd.arr_commit | cmd.mark_set;
		mark_wd = cmd.mark_set;
		mark_wa = cmd.mark_set ? id_m1 : AW'(next_id_q - ID_W'(1));
	end

	always_ff @(posedge clk) begin
		if (heap_we) begin
			heap_mem[pos_q] <= heap_wd;
		end
		rd0_q <= heap_mem[ra0];
		rd1_q <= heap_mem[ra1];
		if (mark_we) begin
			marks_mem[mark_wa] <= mark_wd;
		end
		mark_q <= marks_mem[id_m1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_id_q <= ID_W'(1);
			fifo_cnt_q <= '0;
			size_q <= '0;
		end else begin
			if (cmd.arr_commit) begin
				next_id_q <= next_id_q + ID_W'(1);
				fifo_cnt_q <= fifo_cnt_q + ID_W'(1);
				size_q <= size_q + ID_W'(1);
			end
			if (cmd.fifo_pop) begin
				fifo_cnt_q <= fifo_cnt_q - ID_W'(1);
			end
			if (cmd.hpop_rd) begin
				size_q <= size_q - ID_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.arr_commit) begin
			pos_q <= size_q[AW-1:0];
			item_q <= {vmask, next_id_q};
		end
		if (cmd.up_move) begin
			pos_q <= up_idx;
		end
		if (cmd.fifo_pop) begin
			id_q <= next_id_q - fifo_cnt_q;
		end
		if (cmd.h_take) begin
			id_q <= rd0_q[ID_W-1:0];
			last_q <= rd1_q;
			pos_q <= '0;
		end
		if (cmd.dn_move) begin
			pos_q <= pick1 ? c1_idx[AW-1:0] : c_idx[AW-1:0];
		end
	end

	assign id = id_q;
endmodule

// ===== rtl/fpds_ctrl.sv =====
// Controller state machine of the request queue.
`timescale 1ns / 1ps
module fpds_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [1:0] kind,
	input  fpds_pkg::stat_t stat,
	output fpds_pkg::cmd_t cmd,
	output logic busy,
	output logic done,
	output logic [1:0] status
);
	typedef enum logic [3:0] {
		S_IDLE, S_UP_RD, S_UP_CMP, S_F_POP, S_H_POP, S_H_TAKE,
		S_DN_RD, S_DN_CMP, S_MARK_RD, S_MARK
	} state_t;

	state_t state_q, state_d;
	logic [1:0] kind_q;
	logic done_d;
	logic [1:0] status_d;
	logic done_q;
	logic [1:0] status_q;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		done_d = 1'b0;
		status_d = fpds_pkg::ST_SERVED;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					case (kind)
						fpds_pkg::KIND_ARRIVE: begin
							if (stat.full) begin
								done_d = 1'b1;
								status_d = fpds_pkg::ST_FULL;
							end else begin
								cmd.arr_commit = 1'b1;
								state_d = S_UP_RD;
							end
						end
						fpds_pkg::KIND_OLDEST: state_d = S_F_POP;
						fpds_pkg::KIND_HIGHEST: state_d = S_H_POP;
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_UP_RD: begin
				if (stat.up_root) begin
					cmd.up_place = 1'b1;
					state_d = S_IDLE;
				end else begin
					cmd.up_rd = 1'b1;
					state_d = S_UP_CMP;
				end
			end
			S_UP_CMP: begin
				if (stat.up_go) begin
					cmd.up_move = 1'b1;
					state_d = S_UP_RD;
				end else begin
					cmd.up_place = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_F_POP: begin
				if (stat.fifo_empty) begin
					done_d = 1'b1;
					status_d = fpds_pkg::ST_EMPTY;
					state_d = S_IDLE;
				end else begin
					cmd.fifo_pop = 1'b1;
					state_d = S_MARK_RD;
				end
			end
			S_H_POP: begin
				if (stat.heap_empty) begin
					done_d = 1'b1;
					status_d = fpds_pkg::ST_EMPTY;
					state_d = S_IDLE;
				end else begin
					cmd.hpop_rd = 1'b1;
					state_d = S_H_TAKE;
				end
			end
			S_H_TAKE: begin
				cmd.h_take = 1'b1;
				state_d = stat.heap_empty ? S_MARK_RD : S_DN_RD;
			end
			S_DN_RD: begin
				if (stat.dn_end) begin
					cmd.dn_place = 1'b1;
					state_d = S_MARK_RD;
				end else begin
					state_d = S_DN_CMP;
				end
			end
			S_DN_CMP: begin
				if (stat.dn_go) begin
					cmd.dn_move = 1'b1;
					state_d = S_DN_RD;
				end else begin
					cmd.dn_place = 1'b1;
					state_d = S_MARK_RD;
				end
			end
			S_MARK_RD: state_d = S_MARK;
			S_MARK: begin
				if (stat.marked) begin
					state_d = (kind_q == fpds_pkg::KIND_OLDEST) ? S_F_POP : S_H_POP;
				end else begin
					cmd.mark_set = 1'b1;
					done_d = 1'b1;
					status_d = fpds_pkg::ST_SERVED;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			kind_q <= fpds_pkg::KIND_ARRIVE;
			done_q <= 1'b0;
			status_q <= fpds_pkg::ST_SERVED;
		end else begin
			state_q <= state_d;
			if (state_q == S_IDLE && start) begin
				kind_q <= kind;
			end
			done_q <= done_d;
			status_q <= status_d;
		end
	end

	assign busy = state_q != S_IDLE;
	assign done = done_q;
	assign status = status_q;
endmodule

// ===== rtl/fifo_and_priority_dual_server_top.sv =====
// Top level of the dual-policy request queue (oldest-first and highest-value-first).
`timescale 1ns / 1ps
`include "fifo_and_priority_dual_server_top_macros.svh"
// A word is taken at a rising edge where start is high and busy is low. The word
// carries kind (arrival, serve oldest, serve highest) and value (arrival priority).
// An arrival gets the next id from 1 up and enters a FIFO order and a max-heap.
// Results appear on served_id and status for one cycle, marked by done, and the
// receiver cannot hold them off.
// Work after the word is taken: an accepted arrival returns no word and sifts up,
// through S_UP_RD and S_UP_CMP for each heap level compared, until its parent ranks
// at least as high or it reaches the root. A full arrival answers in the next cycle.
// A serve-oldest pops FIFO entries through S_F_POP, S_MARK_RD and S_MARK, reading
// the served mark of each, and answers empty when none is left. A serve-highest
// reads the root and last entry (S_H_POP, S_H_TAKE), sifts down through S_DN_RD and
// S_DN_CMP per heap level unless the heap is then empty, and checks the served mark
// (S_MARK_RD, S_MARK) per entry popped; it answers empty when the heap runs empty.
// done follows the work; entries served by the other policy are skipped.
// busy is high while a word is in work; done is shown once the state machine is
// back at rest, so a new word may be taken in the cycle its result is shown.
// Reset sets the id counter to 1 and clears the FIFO count and the heap size; served
// marks are cleared per entry as ids are issued, so no clearing pass is needed.
module fifo_and_priority_dual_server_top #(
	parameter int VALUE_WIDTH = 20
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic [1:0] kind,
	input  logic [19:0] value,
	output logic done,
	output logic [10:0] served_id,
	output logic [1:0] status
);
	fpds_pkg::cmd_t cmd;
	fpds_pkg::stat_t stat;
	logic [fpds_pkg::ID_W-1:0] dp_id;

	fpds_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.kind(kind),
		.stat(stat),
		.cmd(cmd),
		.busy(busy),
		.done(done),
		.status(status)
	);

	fpds_dp #(.VALUE_WIDTH(VALUE_WIDTH)) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.value(value),
		.cmd(cmd),
		.stat(stat),
		.id(dp_id)
	);

	assign served_id = (status == fpds_pkg::ST_SERVED) ? dp_id : '0;

	`FPDS_ASSERT_NOW(a_served_nonzero, done && status == fpds_pkg::ST_SERVED, served_id != '0, "served word without id")
	`FPDS_ASSERT_NOW(a_done_cause, done, $past(busy) || $past(start), "result without work")
	`FPDS_ASSERT_NOW(a_status_code, done, status == fpds_pkg::ST_SERVED || status == fpds_pkg::ST_EMPTY || status == fpds_pkg::ST_FULL, "bad status code")
endmodule

// ===== tb/tb_fifo_and_priority_dual_server_top.sv =====
// Testbench for the dual-policy request queue: directed table plus random words, checked by a predictor.
`timescale 1ns / 1ps
module tb_fifo_and_priority_dual_server_top;
	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int LIMIT = 3000000;
	localparam logic CHK = 1'b1;
	localparam logic PRED = 1'b0;

	typedef struct {
		logic [1:0] kind;
		logic [19:0] value;
		logic fixed;
		logic [10:0] id;
		logic [1:0] st;
	} row_t;

	typedef struct {
		logic [10:0] id;
		logic [1:0] st;
	} answer_t;

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic [1:0] kind = 0;
	logic [19:0] value = 0;
	logic busy, done;
	logic [10:0] served_id;
	logic [1:0] status;

	int issued;
	int ring[$];
	int hval[$];
	int hid[$];
	bit marks[int];
	answer_t answers_due[$];
	int errors = 0;
	int cycles = 0;
	int sender_idle = 0;
	row_t rows[$];

	fifo_and_priority_dual_server_top dut (.*);

	initial forever #2 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic report(input string what);
		$display("mismatch at cycle %0d: %s", cycles, what);
		errors++;
	endtask

	// Predicts the answer to one word; returns 0 when the word yields none.
	function automatic bit queue_answer(input logic [1:0] k, input logic [19:0] v,
			output answer_t a);
		int best, id;
		a.id = 0;
		a.st = fpds_pkg::ST_EMPTY;
		if (k == fpds_pkg::KIND_ARRIVE) begin
			if (issued >= fpds_pkg::CAPACITY) begin
				a.st = fpds_pkg::ST_FULL;
				return 1;
			end
			issued++;
			ring.push_back(issued);
			hval.push_back(v);
			hid.push_back(issued);
			return 0;
		end
		if (k == fpds_pkg::KIND_OLDEST) begin
			while (ring.size() > 0) begin
				id = ring.pop_front();
				if (!marks.exists(id)) begin
					a.id = id;
					a.st = fpds_pkg::ST_SERVED;
					break;
				end
			end
		end else if (k == fpds_pkg::KIND_HIGHEST) begin
			while (hid.size() > 0) begin
				best = 0;
				foreach (hid[i])
					if (hval[i] > hval[best] || (hval[i] == hval[best] && hid[i] < hid[best]))
						best = i;
				id = hid[best];
				hid.delete(best);
				hval.delete(best);
				if (!marks.exists(id)) begin
					a.id = id;
					a.st = fpds_pkg::ST_SERVED;
					break;
				end
			end
		end else
			return 0;
		if (a.st == fpds_pkg::ST_SERVED)
			marks[id] = 1;
		return 1;
	endfunction

	always @(posedge clk) begin
		answer_t e;
		if (arst_n && done) begin
			if (answers_due.size() == 0)
				report("result with nothing expected");
			else begin
				e = answers_due.pop_front();
				if (served_id !== e.id)
					report($sformatf("served_id %0d, expected %0d", served_id, e.id));
				if (status !== e.st)
					report($sformatf("status %0d, expected %0d", status, e.st));
			end
		end
	end

	task automatic send(input logic [1:0] k, input logic [19:0] v, input logic fx,
			input logic [10:0] xid, input logic [1:0] xst);
		answer_t a;
		bit has;
		while ($urandom_range(99) < sender_idle) begin
			start <= 0;
			@(posedge clk);
		end
		start <= 1;
		kind <= k;
		value <= v;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		has = queue_answer(k, v, a);
		if (fx) begin
			a.id = xid;
			a.st = xst;
		end
		if (has)
			answers_due.push_back(a);
	endtask

	function automatic logic [19:0] rand_value();
		case ($urandom_range(3))
			0: return 20'h0;
			1: return 20'hFFFFF;
			2: return 20'($urandom_range(7));
			default: return 20'($urandom);
		endcase
	endfunction

	initial begin
		int phase, n, r;
		rows = '{
			'{fpds_pkg::KIND_OLDEST, 20'h0, CHK, 11'd0, fpds_pkg::ST_EMPTY},
			'{fpds_pkg::KIND_HIGHEST, 20'hFFFFF, CHK, 11'd0, fpds_pkg::ST_EMPTY},
			'{KIND_UNUSED, 20'hABCDE, PRED, 0, 0},
			'{fpds_pkg::KIND_ARRIVE, 20'h00000, PRED, 0, 0},
			'{fpds_pkg::KIND_ARRIVE, 20'hFFFFF, PRED, 0, 0},
			'{fpds_pkg::KIND_ARRIVE, 20'h55555, PRED, 0, 0},
			'{fpds_pkg::KIND_ARRIVE, 20'hFFFFF, PRED, 0, 0},
			'{fpds_pkg::KIND_ARRIVE, 20'hAAAAA, PRED, 0, 0},
			'{fpds_pkg::KIND_HIGHEST, 20'h0, CHK, 11'd2, fpds_pkg::ST_SERVED},
			'{fpds_pkg::KIND_OLDEST, 20'h0, CHK, 11'd1, fpds_pkg::ST_SERVED},
			'{fpds_pkg::KIND_OLDEST, 20'h0, CHK, 11'd3, fpds_pkg::ST_SERVED},
			'{fpds_pkg::KIND_HIGHEST, 20'h0, CHK, 11'd4, fpds_pkg::ST_SERVED},
			'{fpds_pkg::KIND_HIGHEST, 20'h0, CHK, 11'd5, fpds_pkg::ST_SERVED},
			'{fpds_pkg::KIND_OLDEST, 20'h0, PRED, 0, 0},
			'{fpds_pkg::KIND_HIGHEST, 20'h0, PRED, 0, 0},
			'{fpds_pkg::KIND_ARRIVE, 20'h12345, PRED, 0, 0},
			'{KIND_UNUSED, 20'h0, PRED, 0, 0},
			'{fpds_pkg::KIND_OLDEST, 20'hFFFFF, PRED, 0, 0}
		};
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		foreach (rows[i])
			send(rows[i].kind, rows[i].value, rows[i].fixed, rows[i].id, rows[i].st);
		for (phase = 0; phase < 3; phase++) begin
			sender_idle = (phase == 0) ? 33 : (phase == 1) ? 49 : 0;
			for (n = 0; n < 75; n++) begin
				r = $urandom_range(99);
				if (r < 55)
					send(fpds_pkg::KIND_ARRIVE, rand_value(), PRED, 0, 0);
				else if (r < 76)
					send(fpds_pkg::KIND_OLDEST, 20'($urandom), PRED, 0, 0);
				else if (r < 97)
					send(fpds_pkg::KIND_HIGHEST, 20'($urandom), PRED, 0, 0);
				else
					send(KIND_UNUSED, 20'($urandom), PRED, 0, 0);
			end
		end
		// Push past capacity so the full case is reached, then serve six words of each policy.
		while (issued < fpds_pkg::CAPACITY)
			send(fpds_pkg::KIND_ARRIVE, rand_value(), PRED, 0, 0);
		repeat (3)
			send(fpds_pkg::KIND_ARRIVE, rand_value(), PRED, 0, 0);
		repeat (6) begin
			send(fpds_pkg::KIND_OLDEST, 20'h0, PRED, 0, 0);
			send(fpds_pkg::KIND_HIGHEST, 20'h0, PRED, 0, 0);
		end
		start <= 0;
		n = 0;
		while (answers_due.size() > 0 && n < 100000) begin
			@(posedge clk);
			n++;
		end
		repeat (50) @(posedge clk);
		if (errors == 0 && answers_due.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/fpds_pkg.sv
rtl/fpds_dp.sv
rtl/fpds_ctrl.sv
rtl/fifo_and_priority_dual_server_top.sv
tb/tb_fifo_and_priority_dual_server_top.sv
